@@ rtl/ble_midi_packet_parser_macros.svh @@
// ----------------------------------------------------------------------------
// ble midi packet parser assertion macros
// shared concurrent assertion forms for the parser checkers
// ----------------------------------------------------------------------------
`ifndef BLE_MIDI_PACKET_PARSER_MACROS_SVH
`define BLE_MIDI_PACKET_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BMPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmpp assertion failed");

// next-cycle implication, disabled during reset
`define BMPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmpp assertion failed");

`endif

@@ rtl/bmpp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpp_pkg
// shared types, constants and helpers of the ble midi packet parser
// ----------------------------------------------------------------------------
`default_nettype none

package bmpp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 512;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PLEN_W = 10;
  localparam int unsigned POS_W = 10;
  localparam int unsigned TIME_W = 13;
  localparam int unsigned FAULT_W = 3;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // saturation bound of the packet length, kept within the length field
  localparam int unsigned EFF_MAX = (MAX_PACKET_BYTES > (2 ** PLEN_W) - 1) ?
                                    (2 ** PLEN_W) - 1 : MAX_PACKET_BYTES;

  localparam logic [FAULT_W-1:0] FAULT_NONE      = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_SHORT     = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_TS_ONLY   = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_TRUNCATED = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_NO_RUN    = 3'd4;

  // lowest field in the lowest bits
  typedef struct packed {
    logic [FAULT_W-1:0] fault;
    logic [TIME_W-1:0]  event_time;
    logic [BYTE_W-1:0]  second_data;
    logic [BYTE_W-1:0]  first_data;
    logic [BYTE_W-1:0]  status_byte;
    logic [1:0]         event_length;
    logic               event_valid;
  } evt_t;

  typedef struct packed {
    logic emit;
    evt_t evt;
  } res_t;

  function automatic evt_t mk_event(logic [1:0] len, logic [BYTE_W-1:0] st,
                                    logic [BYTE_W-1:0] d1, logic [BYTE_W-1:0] d2,
                                    logic [TIME_W-1:0] t);
    evt_t e;
    e.event_valid  = 1'b1;
    e.event_length = len;
    e.status_byte  = st;
    e.first_data   = (len >= 2'd2) ? d1 : '0;
    e.second_data  = (len == 2'd3) ? d2 : '0;
    e.event_time   = t;
    e.fault        = FAULT_NONE;
    return e;
  endfunction

  function automatic evt_t mk_fault(logic [FAULT_W-1:0] code);
    evt_t e;
    e       = '0;
    e.fault = code;
    return e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ble_midi_packet_parser.sv @@
// ----------------------------------------------------------------------------
// ble_midi_packet_parser
// decodes ble-midi packets byte by byte into midi events with timestamps
// ----------------------------------------------------------------------------
// usage
//   slave stream: one packet byte per transfer, with the packet length
//   repeated on every byte. master stream: one transfer per completed midi
//   event or per fault; bytes that complete nothing give no transfer.
//   flow: an accepted byte is held in the input register, decoded when the
//   result register is free and shows on the master side from that register.
//   throughput: one byte per cycle while the receiver does not stall, set by
//   the combinational decode between the input register and the result register.
//   reset: parser returns to awaiting a packet header, running status and
//   timestamps clear, both streams go empty.
//   receiver stall: a waiting result holds; the input register keeps one
//   byte, after which s_axis_tready_o drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_midi_packet_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // packet_byte[7:0], packet_length[17:8], zero pad
  input  wire logic [bmpp_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // event_valid[0], event_length[2:1], status_byte[10:3], first_data[18:11],
  // second_data[26:19], event_time[39:27], fault[42:40], zero pad
  output logic [bmpp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i
);
  import bmpp_pkg::*;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic [PLEN_W-1:0] in_len_q;
  logic              out_busy;
  logic              fire;
  res_t              res;

  assign fire            = in_valid_q && !out_busy;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i[BYTE_W-1:0];
      in_len_q  <= s_axis_tdata_i[BYTE_W +: PLEN_W];
    end
  end

  bmpp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .byte_i (in_byte_q),
    .len_i  (in_len_q),
    .res_o  (res)
  );

  bmpp_out_buf u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (fire),
    .res_i           (res),
    .busy_o          (out_busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ rtl/bmpp_core.sv @@
// ----------------------------------------------------------------------------
// bmpp_core
// parser state and single-pass byte decode, one byte per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bmpp_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic [bmpp_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [bmpp_pkg::PLEN_W-1:0] len_i,
  output bmpp_pkg::res_t                   res_o
);
  import bmpp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BOUND   = 2'd1,
    PH_AFTER_TS = 2'd2,
    PH_DATA    = 2'd3
  } phase_e;

  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_MTC_QF      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_SC_ONE_MIN  = 8'hF4;
  localparam logic [7:0] ST_RT_MIN      = 8'hF8;
  localparam logic [7:0] ST_CH2_MIN     = 8'hC0;
  localparam logic [7:0] ST_CH2_MAX     = 8'hDF;
  localparam logic [7:0] ST_MIN         = 8'h80;

  phase_e             phase_q, phase_d;
  logic               rej_q, rej_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         rs_q, rs_d;
  logic [1:0]         rl_q, rl_d;
  logic [7:0]         cs_q, cs_d;
  logic [1:0]         cl_q, cl_d;
  logic [1:0]         rem_q, rem_d;
  logic [7:0]         held_q, held_d;
  logic [5:0]         th_q, th_d;
  logic [6:0]         tl_q, tl_d;

  logic [PLEN_W-1:0]  eff;
  logic               last;
  logic               do_start;
  logic [TIME_W-1:0]  t_now;

  assign eff   = (len_i > EFF_MAX[PLEN_W-1:0]) ? EFF_MAX[PLEN_W-1:0] : len_i;
  assign last  = ({1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1}) >= {1'b0, eff};
  assign t_now = {th_q, tl_q};

  always_comb begin
    phase_d    = phase_q;
    rej_d      = rej_q;
    pos_d      = pos_q;
    rs_d       = rs_q;
    rl_d       = rl_q;
    cs_d       = cs_q;
    cl_d       = cl_q;
    rem_d      = rem_q;
    held_d     = held_q;
    th_d       = th_q;
    tl_d       = tl_q;
    do_start   = 1'b0;
    res_o.emit = 1'b0;
    res_o.evt  = '0;

    if (phase_q == PH_HEADER) begin
      th_d    = byte_i[5:0];
      phase_d = PH_BOUND;
      if (eff < PLEN_W'(3)) begin
        rej_d      = 1'b1;
        res_o.emit = 1'b1;
        res_o.evt  = mk_fault(FAULT_SHORT);
      end
    end else if (!rej_q) begin
      unique case (phase_q)
        PH_BOUND: begin
          if (byte_i[7]) begin
            tl_d    = byte_i[6:0];
            phase_d = PH_AFTER_TS;
          end else begin
            do_start = 1'b1;
          end
        end
        PH_AFTER_TS: do_start = 1'b1;
        PH_DATA: begin
          if (rem_q >= 2'd2) begin
            held_d = byte_i;
            rem_d  = 2'd1;
          end else begin
            phase_d    = PH_BOUND;
            rem_d      = 2'd0;
            res_o.emit = 1'b1;
            if (cl_q == 2'd3) begin
              res_o.evt = mk_event(2'd3, cs_q, held_q, byte_i, t_now);
            end else begin
              res_o.evt = mk_event(2'd2, cs_q, byte_i, 8'h00, t_now);
            end
          end
        end
        default: ;
      endcase
    end

    if (do_start) begin
      phase_d = PH_BOUND;
      if (byte_i >= ST_RT_MIN) begin
        res_o.emit = 1'b1;
        res_o.evt  = mk_event(2'd1, byte_i, 8'h00, 8'h00, t_now);
      end else if (byte_i == ST_SYSEX_START || byte_i == ST_SYSEX_END) begin
        rs_d       = byte_i;
        rl_d       = 2'd1;
        res_o.emit = 1'b1;
        res_o.evt  = mk_event(2'd1, byte_i, 8'h00, 8'h00, t_now);
      end else if (byte_i == ST_MTC_QF || byte_i == ST_SONG_SEL) begin
        cs_d    = byte_i;
        cl_d    = 2'd2;
        rem_d   = 2'd1;
        phase_d = PH_DATA;
      end else if (byte_i == ST_SONG_POS) begin
        cs_d    = byte_i;
        cl_d    = 2'd3;
        rem_d   = 2'd2;
        phase_d = PH_DATA;
      end else if (byte_i >= ST_SC_ONE_MIN) begin
        res_o.emit = 1'b1;
        res_o.evt  = mk_event(2'd1, byte_i, 8'h00, 8'h00, t_now);
      end else if (byte_i >= ST_CH2_MIN && byte_i <= ST_CH2_MAX) begin
        rs_d    = byte_i;
        rl_d    = 2'd2;
        cs_d    = byte_i;
        cl_d    = 2'd2;
        rem_d   = 2'd1;
        phase_d = PH_DATA;
      end else if (byte_i >= ST_MIN) begin
        rs_d    = byte_i;
        rl_d    = 2'd3;
        cs_d    = byte_i;
        cl_d    = 2'd3;
        rem_d   = 2'd2;
        phase_d = PH_DATA;
      end else if (rs_q == ST_SYSEX_START) begin
        res_o.emit = 1'b1;
        res_o.evt  = mk_event(2'd1, byte_i, 8'h00, 8'h00, t_now);
      end else if (rl_q < 2'd2) begin
        res_o.emit = 1'b1;
        res_o.evt  = mk_fault(FAULT_NO_RUN);
      end else begin
        cs_d = rs_q;
        cl_d = rl_q;
        if (rl_q == 2'd2) begin
          res_o.emit = 1'b1;
          res_o.evt  = mk_event(2'd2, rs_q, byte_i, 8'h00, t_now);
        end else begin
          held_d  = byte_i;
          rem_d   = 2'd1;
          phase_d = PH_DATA;
        end
      end
    end

    // packet ends with a lone timestamp or an unfinished message
    if (last && !res_o.emit && !rej_d) begin
      if (phase_d == PH_AFTER_TS) begin
        res_o.emit = 1'b1;
        res_o.evt  = mk_fault(FAULT_TS_ONLY);
      end else if (phase_d == PH_DATA) begin
        res_o.emit = 1'b1;
        res_o.evt  = mk_fault(FAULT_TRUNCATED);
      end
    end

    if (last) begin
      pos_d   = '0;
      phase_d = PH_HEADER;
      rej_d   = 1'b0;
      rem_d   = 2'd0;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      rej_q   <= 1'b0;
      pos_q   <= '0;
      rs_q    <= '0;
      rl_q    <= '0;
      cs_q    <= '0;
      cl_q    <= '0;
      rem_q   <= '0;
      held_q  <= '0;
      th_q    <= '0;
      tl_q    <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      rej_q   <= rej_d;
      pos_q   <= pos_d;
      rs_q    <= rs_d;
      rl_q    <= rl_d;
      cs_q    <= cs_d;
      cl_q    <= cl_d;
      rem_q   <= rem_d;
      held_q  <= held_d;
      th_q    <= th_d;
      tl_q    <= tl_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmpp_out_buf.sv @@
// ----------------------------------------------------------------------------
// bmpp_out_buf
// result register of the master stream, loaded by the decode stage
// ----------------------------------------------------------------------------
`default_nettype none

module bmpp_out_buf (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  bmpp_pkg::res_t                       res_i,
  output logic                                 busy_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [bmpp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);
  import bmpp_pkg::*;

  logic valid_q;
  evt_t evt_q;

  // stage is blocked while a result waits and the receiver stalls
  assign busy_o          = valid_q && !m_axis_tready_i;
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - $bits(evt_t))'(0), evt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && res_i.emit) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.emit) begin
      evt_q <= res_i.evt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmpp_checker.sv @@
// ----------------------------------------------------------------------------
// bmpp_checker
// port-level checks of the parser result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ble_midi_packet_parser_macros.svh"

module bmpp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [bmpp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import bmpp_pkg::*;

  // stalled result holds
  `BMPP_ASSERT_NXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // an event carries no fault and a length of one to three
  `BMPP_ASSERT_IMP(a_event_shape, m_axis_tvalid_o && m_axis_tdata_o[0], m_axis_tdata_o[42:40] == FAULT_NONE && m_axis_tdata_o[2:1] != 2'd0)

  // a fault transfer carries a known code and nothing else
  `BMPP_ASSERT_IMP(a_fault_shape, m_axis_tvalid_o && !m_axis_tdata_o[0], m_axis_tdata_o[39:1] == '0 && m_axis_tdata_o[42:40] != FAULT_NONE && m_axis_tdata_o[42:40] <= FAULT_NO_RUN)

  // a one-byte event carries zero data bytes
  `BMPP_ASSERT_IMP(a_short_event, m_axis_tvalid_o && m_axis_tdata_o[2:1] == 2'd1, m_axis_tdata_o[26:11] == '0)

endmodule

bind ble_midi_packet_parser bmpp_checker u_bmpp_checker (.*);

`default_nettype wire

@@ dv/ble_midi_packet_parser_tb.sv @@
// ----------------------------------------------------------------------------
// ble_midi_packet_parser_tb
// self-checking bench: packet bytes go in over the slave stream and every
// event or fault that comes out is matched, field by field and in order,
// against a cycle-free software decoder kept inside the bench. directed
// packets hit the corner cases and a long receiver hold-off, then random
// packets with gaps and stalls on both sides and a gap-free stretch at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_midi_packet_parser_tb;
  import bmpp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_BOUNDARY = 2'd1;
  localparam logic [1:0] PH_AFTER_TS = 2'd2;
  localparam logic [1:0] PH_COLLECT  = 2'd3;

  localparam logic [7:0] CHAN_FIRST     = 8'h80;
  localparam logic [7:0] CHAN_TWO_FIRST = 8'hC0;
  localparam logic [7:0] CHAN_TWO_LAST  = 8'hDF;
  localparam logic [7:0] CHAN_PB_FIRST  = 8'hE0;
  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] MTC_QUARTER    = 8'hF1;
  localparam logic [7:0] SONG_POSITION  = 8'hF2;
  localparam logic [7:0] SONG_SELECT    = 8'hF3;
  localparam logic [7:0] COMMON_SINGLE  = 8'hF4;
  localparam logic [7:0] TUNE_REQUEST   = 8'hF6;
  localparam logic [7:0] SYSEX_END      = 8'hF7;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;
  localparam logic [7:0] REALTIME_LAST  = 8'hFF;
  localparam logic [7:0] TS_MARK        = 8'h80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] src_data = '0;
  logic src_valid = 1'b0;
  logic src_ready;
  logic [OUT_DATA_W-1:0] sink_data;
  logic sink_valid;
  logic sink_ready = 1'b0;

  ble_midi_packet_parser i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (src_data),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .m_axis_tdata_o  (sink_data),
    .m_axis_tvalid_o (sink_valid),
    .m_axis_tready_i (sink_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder state
  logic [9:0] rx_pos = '0;
  logic [1:0] rx_phase = PH_HEADER;
  logic       rx_rejected = 1'b0;
  logic [7:0] run_status = '0;
  logic [1:0] run_len = '0;
  logic [7:0] msg_status = '0;
  logic [1:0] msg_len = '0;
  logic [1:0] msg_left = '0;
  logic [7:0] held_byte = '0;
  logic [5:0] stamp_high = '0;
  logic [6:0] stamp_low = '0;

  evt_t midi_events_q[$];
  evt_t exp_evt;
  evt_t act_evt;

  int unsigned errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_events = 0;
  int unsigned n_faults = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned gap_left = 0;
  bit src_gaps = 1'b0;
  bit sink_gaps = 1'b0;

  function automatic evt_t event_of(logic [1:0] len, logic [7:0] st, logic [7:0] d1,
                                    logic [7:0] d2);
    evt_t ev;
    ev = '0;
    ev.event_valid  = 1'b1;
    ev.event_length = len;
    ev.status_byte  = st;
    ev.first_data   = (len >= 2'd2) ? d1 : 8'h00;
    ev.second_data  = (len == 2'd3) ? d2 : 8'h00;
    ev.event_time   = {stamp_high, stamp_low};
    return ev;
  endfunction

  function automatic evt_t fault_of(logic [FAULT_W-1:0] code);
    evt_t ev;
    ev = '0;
    ev.fault = code;
    return ev;
  endfunction

  function automatic void begin_body(logic [7:0] st, logic [1:0] len);
    msg_status = st;
    msg_len    = len;
    msg_left   = len - 2'd1;
    rx_phase   = PH_COLLECT;
  endfunction

  // first byte of a message, status or running-status data
  function automatic bit open_message(input logic [7:0] b, output evt_t ev);
    ev = '0;
    rx_phase = PH_BOUNDARY;
    if (b >= REALTIME_FIRST) begin
      ev = event_of(2'd1, b, 8'h00, 8'h00);
      return 1'b1;
    end
    if (b == SYSEX_START || b == SYSEX_END) begin
      run_status = b;
      run_len    = 2'd1;
      ev = event_of(2'd1, b, 8'h00, 8'h00);
      return 1'b1;
    end
    if (b == MTC_QUARTER || b == SONG_SELECT) begin
      begin_body(b, 2'd2);
      return 1'b0;
    end
    if (b == SONG_POSITION) begin
      begin_body(b, 2'd3);
      return 1'b0;
    end
    if (b >= COMMON_SINGLE) begin
      ev = event_of(2'd1, b, 8'h00, 8'h00);
      return 1'b1;
    end
    if (b >= CHAN_TWO_FIRST && b <= CHAN_TWO_LAST) begin
      run_status = b;
      run_len    = 2'd2;
      begin_body(b, 2'd2);
      return 1'b0;
    end
    if (b >= CHAN_FIRST) begin
      run_status = b;
      run_len    = 2'd3;
      begin_body(b, 2'd3);
      return 1'b0;
    end
    if (run_status == SYSEX_START) begin
      ev = event_of(2'd1, b, 8'h00, 8'h00);
      return 1'b1;
    end
    if (run_len < 2'd2) begin
      ev = fault_of(FAULT_NO_RUN);
      return 1'b1;
    end
    msg_status = run_status;
    msg_len    = run_len;
    if (run_len == 2'd2) begin
      ev = event_of(2'd2, run_status, b, 8'h00);
      return 1'b1;
    end
    held_byte = b;
    msg_left  = 2'd1;
    rx_phase  = PH_COLLECT;
    return 1'b0;
  endfunction

  function automatic bit collect_data(input logic [7:0] b, output evt_t ev);
    ev = '0;
    if (msg_left >= 2'd2) begin
      held_byte = b;
      msg_left  = 2'd1;
      return 1'b0;
    end
    rx_phase = PH_BOUNDARY;
    msg_left = 2'd0;
    if (msg_len == 2'd3)
      ev = event_of(2'd3, msg_status, held_byte, b);
    else
      ev = event_of(2'd2, msg_status, b, 8'h00);
    return 1'b1;
  endfunction

  // one packet byte in, at most one event or fault out
  function automatic bit decode_byte(input logic [7:0] b, input logic [9:0] plen,
                                     output evt_t ev);
    int unsigned eff;
    bit last;
    bit got;
    eff  = (plen > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : plen;
    last = (32'(rx_pos) + 1) >= eff;
    got  = 1'b0;
    ev   = '0;
    if (rx_phase == PH_HEADER) begin
      stamp_high = b[5:0];
      rx_phase   = PH_BOUNDARY;
      if (eff < 3) begin
        rx_rejected = 1'b1;
        ev  = fault_of(FAULT_SHORT);
        got = 1'b1;
      end
    end else if (!rx_rejected) begin
      if (rx_phase == PH_BOUNDARY && b[7]) begin
        stamp_low = b[6:0];
        rx_phase  = PH_AFTER_TS;
      end else if (rx_phase == PH_COLLECT) begin
        got = collect_data(b, ev);
      end else begin
        got = open_message(b, ev);
      end
    end
    if (last && !got && !rx_rejected) begin
      if (rx_phase == PH_AFTER_TS) begin
        ev  = fault_of(FAULT_TS_ONLY);
        got = 1'b1;
      end else if (rx_phase == PH_COLLECT) begin
        ev  = fault_of(FAULT_TRUNCATED);
        got = 1'b1;
      end
    end
    if (last) begin
      rx_pos      = '0;
      rx_phase    = PH_HEADER;
      rx_rejected = 1'b0;
      msg_left    = 2'd0;
    end else begin
      rx_pos = rx_pos + 10'd1;
    end
    return got;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v,
               act_v);
      errors++;
    end
  endtask

  // predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    if (src_valid && src_ready) begin
      n_bytes++;
      if (decode_byte(src_data[7:0], src_data[17:8], exp_evt))
        midi_events_q.push_back(exp_evt);
    end
    if (sink_valid && sink_ready) begin
      act_evt = sink_data[$bits(evt_t)-1:0];
      if (act_evt.event_valid)
        n_events++;
      else
        n_faults++;
      if (midi_events_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual 0x%0h", $time,
                 act_evt);
        errors++;
      end else begin
        exp_evt = midi_events_q.pop_front();
        check_field("event_valid", exp_evt.event_valid, act_evt.event_valid);
        check_field("event_length", exp_evt.event_length, act_evt.event_length);
        check_field("status_byte", exp_evt.status_byte, act_evt.status_byte);
        check_field("first_data", exp_evt.first_data, act_evt.first_data);
        check_field("second_data", exp_evt.second_data, act_evt.second_data);
        check_field("event_time", exp_evt.event_time, act_evt.event_time);
        check_field("fault", exp_evt.fault, act_evt.fault);
      end
    end
  end

  // receiver: long hold-off on request, random stall bursts otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      sink_ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      sink_ready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 8);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((src_valid && src_ready) || (sink_valid && sink_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("ble_midi_packet_parser test failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic [9:0] plen);
    src_data  <= {{(IN_DATA_W - 18){1'b0}}, plen, b};
    src_valid <= 1'b1;
    do @(posedge clk); while (!src_ready);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_packet(input logic [7:0] q[$], input logic [9:0] plen);
    foreach (q[i]) push_byte(q[i], plen);
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 15) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] rand_stamp();
    return TS_MARK | 8'($urandom_range(0, 127));
  endfunction

  // header byte, then a message stream of random content with stray random bytes, cut at n bytes
  function automatic void build_packet(input int unsigned n, ref logic [7:0] q[$]);
    int unsigned kind;
    logic [7:0] st;
    q = {};
    q.push_back(8'($urandom_range(0, 255)));
    while (q.size() < n) begin
      kind = $urandom_range(0, 9);
      if (kind > 1 || $urandom_range(0, 3) == 0)
        q.push_back(rand_stamp());
      case (kind)
        0, 1: begin
          q.push_back(rand_data());
          if ($urandom_range(0, 1) == 0) q.push_back(rand_data());
        end
        2, 3: begin
          if ($urandom_range(0, 1) == 0)
            st = CHAN_FIRST + 8'($urandom_range(0, 63));
          else
            st = CHAN_PB_FIRST + 8'($urandom_range(0, 15));
          q.push_back(st);
          q.push_back(rand_data());
          q.push_back(rand_data());
        end
        4: begin
          q.push_back(CHAN_TWO_FIRST + 8'($urandom_range(0, 31)));
          q.push_back(rand_data());
        end
        5: q.push_back(REALTIME_FIRST + 8'($urandom_range(0, 7)));
        6: begin
          q.push_back(SYSEX_START);
          repeat ($urandom_range(0, 4)) q.push_back(rand_data());
          q.push_back(rand_stamp());
          q.push_back(SYSEX_END);
        end
        7: begin
          st = MTC_QUARTER + 8'($urandom_range(0, 5));
          q.push_back(st);
          if (st == MTC_QUARTER || st == SONG_SELECT) begin
            q.push_back(rand_data());
          end else if (st == SONG_POSITION) begin
            q.push_back(rand_data());
            q.push_back(rand_data());
          end
        end
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    while (q.size() > n) void'(q.pop_back());
  endfunction

  task automatic test_short_packets();
    push_byte(REALTIME_LAST, 10'd0);
    push_byte(8'h00, 10'd2);
    push_byte(8'h7F, 10'd2);
  endtask

  task automatic test_message_classes();
    logic [7:0] q[$];
    // channel, running status, two-byte channel, timestamp left at packet end
    q = {8'hFF, 8'hFF, CHAN_FIRST, 8'h7F, 8'h00, 8'h12, 8'h34, 8'h81,
         CHAN_TWO_LAST, 8'h7F, 8'h85};
    send_packet(q, 10'd11);
    // sysex pass-through, data after sysex end, realtime, one-byte common,
    // data byte with bit 7 set inside a message cut off at packet end
    q = {8'h00, 8'h80, SYSEX_START, 8'h55, 8'h82, SYSEX_END, 8'h01, 8'h83,
         REALTIME_LAST, 8'h84, TUNE_REQUEST, 8'h85, SONG_POSITION, 8'h80};
    send_packet(q, 10'd14);
  endtask

  task automatic test_saturated_length();
    logic [7:0] q[$];
    build_packet(MAX_PACKET_BYTES, q);
    send_packet(q, 10'h3FF);
  endtask

  task automatic test_receiver_hold();
    logic [7:0] q[$];
    q = {8'h3F, 8'h80, SYSEX_START};
    repeat (60) q.push_back(8'($urandom_range(0, 127)));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    send_packet(q, 10'(q.size()));
  endtask

  task automatic test_random_packets(input int unsigned n_items, input bit with_gaps);
    logic [7:0] q[$];
    logic [9:0] plen;
    int unsigned sent;
    int unsigned mode;
    int unsigned n;
    sent = 0;
    while (sent < n_items) begin
      src_gaps  = with_gaps && ($urandom_range(0, 3) != 0);
      sink_gaps = with_gaps && ($urandom_range(0, 3) != 0);
      mode = $urandom_range(0, 19);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(3, 16);
      if (mode == 0) begin
        plen = 10'($urandom_range(0, 2));
        push_byte(8'($urandom_range(0, 255)), plen);
        if (plen == 10'd2) push_byte(8'($urandom_range(0, 255)), plen);
      end else if (mode == 1) begin
        repeat (n) push_byte(8'($urandom_range(0, 255)), 10'(n));
        sent += n;
      end else if (mode <= 3) begin
        // length field large until the byte that ends the packet
        build_packet(n, q);
        foreach (q[i]) begin
          if (i == q.size() - 1)
            push_byte(q[i], 10'($urandom_range(0, n)));
          else
            push_byte(q[i], 10'($urandom_range(n, 1023)));
        end
        sent += n;
      end else begin
        build_packet(n, q);
        send_packet(q, 10'(n));
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_packets();
    test_message_classes();
    test_saturated_length();
    test_receiver_hold();
    test_random_packets(100, 1'b1);
    test_random_packets(50, 1'b0);
    src_valid <= 1'b0;
    while (midi_events_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d packet bytes decoded, %0d events and %0d faults compared", n_bytes,
             n_events, n_faults);
    $display("covered all message classes, running status, bad packets and long stalls");
    if (errors == 0)
      $display("ble_midi_packet_parser test passed");
    else
      $display("ble_midi_packet_parser test failed");
    $finish;
  end

endmodule

`default_nettype wire
